>>> sv/rcv_pkg.sv
package rcv_pkg;

  // Channel and coefficient widths follow the fixed field widths of the ports.
  localparam int PIX_BITS   = 8;
  localparam int COEF_BITS  = 8;
  localparam int CHANNELS   = 3;
  localparam int PX_BITS    = CHANNELS * PIX_BITS;
  localparam int LB_BITS    = 2 * PX_BITS;
  localparam int KROWS      = 3;
  localparam int KCOLS      = 3;
  localparam int TAPS       = KROWS * KCOLS;

  // An unsigned pixel times a signed coefficient fits in the sum of both widths.
  localparam int PROD_BITS  = PIX_BITS + COEF_BITS;
  localparam int ACC_BITS   = PROD_BITS + 4;
  localparam int OUT_BITS   = 8;
  localparam int OUT_MAX    = 255;

  // Configuration register widths.
  localparam int LW_BITS    = 12;
  localparam int FH_BITS    = 13;
  localparam int KROW_BITS  = KCOLS * COEF_BITS;
  localparam int SHIFT_BITS = 4;
  localparam int CFG_BITS   = 24;
  localparam int IDX_BITS   = 3;
  localparam int ROW_BITS   = 12;

  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;
  localparam int BORDER     = 2;

  localparam logic [LW_BITS-1:0]    LW_RESET    = 12'd640;
  localparam logic [FH_BITS-1:0]    FH_RESET    = 13'd480;
  localparam logic [KROW_BITS-1:0]  KROW0_RESET = 24'h010201;
  localparam logic [KROW_BITS-1:0]  KROW1_RESET = 24'h020802;
  localparam logic [KROW_BITS-1:0]  KROW2_RESET = 24'h010201;
  localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 4'd4;

  typedef enum logic [IDX_BITS-1:0] {
    REG_LINE_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_KERNEL_ROW0  = 3'd2,
    REG_KERNEL_ROW1  = 3'd3,
    REG_KERNEL_ROW2  = 3'd4,
    REG_NORM_SHIFT   = 3'd5
  } reg_idx_e;

  typedef logic        [PIX_BITS-1:0]  pix_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;
  typedef logic        [PX_BITS-1:0]   px_t;

endpackage

>>> sv/rgb_conv3x3_pow2_shift.sv
// An accepted input beat passes the line store read, the window update, the product
// register and the result register on its way to the result beat that it completes.
// Throughput: one pixel beat per cycle while out_ready_i does not hold the output back;
// the output register and the product stage let a new beat enter while a result still waits to be taken.
// Reset: asynchronous, active low; clears pipeline valids, counters and configuration registers.
// Line store contents stay undefined after reset; only border rows ever read them.
module rgb_conv3x3_pow2_shift #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rcv_pkg::IDX_BITS-1:0]      cfg_idx_i,
  input  logic [rcv_pkg::CFG_BITS-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rcv_pkg::PIX_BITS-1:0]      pixel_red_i,
  input  logic [rcv_pkg::PIX_BITS-1:0]      pixel_green_i,
  input  logic [rcv_pkg::PIX_BITS-1:0]      pixel_blue_i,
  input  logic                              frame_start_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rcv_pkg::OUT_BITS-1:0]      out_red_o,
  output logic [rcv_pkg::OUT_BITS-1:0]      out_green_o,
  output logic [rcv_pkg::OUT_BITS-1:0]      out_blue_o,
  output logic [rcv_pkg::ROW_BITS-1:0]      out_row_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      out_col_o
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int MwW  = $clog2(MAX_WIDTH + 1);
  // Wide enough for the line width register, the clamp limit and a column plus one.
  localparam int CmpW = ((MwW > rcv_pkg::LW_BITS) ? MwW : rcv_pkg::LW_BITS) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land directly; unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  logic [rcv_pkg::LW_BITS-1:0]    line_width_q;
  logic [rcv_pkg::FH_BITS-1:0]    frame_height_q;
  logic [rcv_pkg::KROW_BITS-1:0]  kernel_q [rcv_pkg::KROWS];
  logic [rcv_pkg::SHIFT_BITS-1:0] norm_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= rcv_pkg::LW_RESET;
      frame_height_q <= rcv_pkg::FH_RESET;
      kernel_q[0]    <= rcv_pkg::KROW0_RESET;
      kernel_q[1]    <= rcv_pkg::KROW1_RESET;
      kernel_q[2]    <= rcv_pkg::KROW2_RESET;
      norm_shift_q   <= rcv_pkg::SHIFT_RESET;
    end else if (cfg_we_i) begin
      unique case (rcv_pkg::reg_idx_e'(cfg_idx_i))
        rcv_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_data_i[rcv_pkg::LW_BITS-1:0];
        rcv_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[rcv_pkg::FH_BITS-1:0];
        rcv_pkg::REG_KERNEL_ROW0:  kernel_q[0]    <= cfg_data_i[rcv_pkg::KROW_BITS-1:0];
        rcv_pkg::REG_KERNEL_ROW1:  kernel_q[1]    <= cfg_data_i[rcv_pkg::KROW_BITS-1:0];
        rcv_pkg::REG_KERNEL_ROW2:  kernel_q[2]    <= cfg_data_i[rcv_pkg::KROW_BITS-1:0];
        rcv_pkg::REG_NORM_SHIFT:   norm_shift_q   <= cfg_data_i[rcv_pkg::SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake. Each stage moves on when the stage after it is empty
  // or moving too. Beats at border positions leave the window stage without
  // ever entering the product stage.
  // ---------------------------------------------------------------------------
  logic s1_vld_q, w_vld_q, p_vld_q, o_vld_q;
  logic w_emit_q;
  logic o_free, p_free, p_done, w_done, w_free, s1_adv, in_acc, w_to_p;

  assign o_free     = !o_vld_q || out_ready_i;
  assign p_free     = !p_vld_q || o_free;
  assign p_done     = p_vld_q && o_free;
  assign w_to_p     = w_vld_q && w_emit_q && p_free;
  assign w_done     = w_vld_q && (!w_emit_q || p_free);
  assign w_free     = !w_vld_q || w_done;
  assign s1_adv     = s1_vld_q && w_free;
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Position counters. The position of the incoming beat is worked out from
  // the stored counters: frame start clears them, and a counter left beyond a
  // newly written geometry falls back to zero.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0]                 col_q, col_base, col_cur, col_nxt;
  logic [rcv_pkg::ROW_BITS-1:0]    row_q, row_base, row_cur, row_nxt;
  logic [CmpW-1:0]                 lw_ext, w_lim, col_inc;
  logic [rcv_pkg::FH_BITS-1:0]     h_lim, row_inc;
  logic                            emit;

  always_comb begin
    lw_ext = CmpW'(line_width_q);
    if (lw_ext < CmpW'(rcv_pkg::MIN_DIM)) begin
      w_lim = CmpW'(rcv_pkg::MIN_DIM);
    end else if (lw_ext > CmpW'(MAX_WIDTH)) begin
      w_lim = CmpW'(MAX_WIDTH);
    end else begin
      w_lim = lw_ext;
    end

    if (frame_height_q < rcv_pkg::FH_BITS'(rcv_pkg::MIN_DIM)) begin
      h_lim = rcv_pkg::FH_BITS'(rcv_pkg::MIN_DIM);
    end else if (frame_height_q > rcv_pkg::FH_BITS'(rcv_pkg::MAX_HEIGHT)) begin
      h_lim = rcv_pkg::FH_BITS'(rcv_pkg::MAX_HEIGHT);
    end else begin
      h_lim = frame_height_q;
    end

    col_base = frame_start_i ? '0 : col_q;
    row_base = frame_start_i ? '0 : row_q;
    col_cur  = (CmpW'(col_base) >= w_lim) ? '0 : col_base;
    row_cur  = (rcv_pkg::FH_BITS'(row_base) >= h_lim) ? '0 : row_base;

    col_inc  = CmpW'(col_cur) + CmpW'(1);
    row_inc  = rcv_pkg::FH_BITS'(row_cur) + rcv_pkg::FH_BITS'(1);
    col_nxt  = col_inc[ColW-1:0];
    row_nxt  = row_cur;
    if (col_inc >= w_lim) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_lim) ? '0 : row_inc[rcv_pkg::ROW_BITS-1:0];
    end

    // A full neighborhood exists once two rows and two columns lie behind.
    emit = (row_cur >= rcv_pkg::ROW_BITS'(rcv_pkg::BORDER))
        && (col_cur >= ColW'(rcv_pkg::BORDER));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_nxt;
      row_q <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the beat waits here while the line stores return the two pixels
  // above it. Both stores share one memory entry per column: the lower half is
  // the previous row, the upper half the row before that.
  // ---------------------------------------------------------------------------
  rcv_pkg::px_t                   s1_px_q;
  logic [ColW-1:0]                s1_col_q;
  logic [ColW-1:0]                s1_ocol_q;
  logic [rcv_pkg::ROW_BITS-1:0]   s1_orow_q;
  logic                           s1_emit_q;
  logic [rcv_pkg::LB_BITS-1:0]    lb_rd;
  rcv_pkg::px_t                   above1, above2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q   <= {pixel_blue_i, pixel_green_i, pixel_red_i};
      s1_col_q  <= col_cur;
      s1_ocol_q <= col_cur - ColW'(1);
      s1_orow_q <= row_cur - rcv_pkg::ROW_BITS'(1);
      s1_emit_q <= emit;
    end
  end

  assign above1 = lb_rd[rcv_pkg::PX_BITS-1:0];
  assign above2 = lb_rd[rcv_pkg::LB_BITS-1:rcv_pkg::PX_BITS];

  rcv_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_cur),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({above1, s1_px_q}),
    .rd_data_o (lb_rd)
  );

  // ---------------------------------------------------------------------------
  // Window stage. Row 0 holds the newest row, column 0 the newest column; the
  // window shifts by one column for every beat that leaves stage 1.
  // ---------------------------------------------------------------------------
  rcv_pkg::px_t                   win_q [rcv_pkg::KROWS][rcv_pkg::KCOLS];
  logic [ColW-1:0]                w_col_q;
  logic [rcv_pkg::ROW_BITS-1:0]   w_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_vld_q  <= 1'b0;
      w_emit_q <= 1'b0;
    end else if (s1_adv) begin
      w_vld_q  <= 1'b1;
      w_emit_q <= s1_emit_q;
    end else if (w_done) begin
      w_vld_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      for (int r = 0; r < rcv_pkg::KROWS; r++) begin
        win_q[r][2] <= win_q[r][1];
        win_q[r][1] <= win_q[r][0];
      end
      win_q[0][0] <= s1_px_q;
      win_q[1][0] <= above1;
      win_q[2][0] <= above2;
      w_col_q     <= s1_ocol_q;
      w_row_q     <= s1_orow_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Product stage: nine products per channel, registered. Tap (r, c) pairs
  // kernel coefficient (r, c) with window pixel (r, c), which makes this a true
  // convolution around the center pixel.
  // ---------------------------------------------------------------------------
  rcv_pkg::coef_t                 coef_taps [rcv_pkg::TAPS];
  rcv_pkg::pix_t                  pix_taps  [rcv_pkg::CHANNELS][rcv_pkg::TAPS];
  rcv_pkg::prod_t                 prod_w    [rcv_pkg::CHANNELS][rcv_pkg::TAPS];
  rcv_pkg::prod_t                 prod_q    [rcv_pkg::CHANNELS][rcv_pkg::TAPS];
  logic [ColW-1:0]                p_col_q;
  logic [rcv_pkg::ROW_BITS-1:0]   p_row_q;

  always_comb begin
    for (int r = 0; r < rcv_pkg::KROWS; r++) begin
      for (int c = 0; c < rcv_pkg::KCOLS; c++) begin
        coef_taps[r * rcv_pkg::KCOLS + c] =
          rcv_pkg::coef_t'(kernel_q[r][c * rcv_pkg::COEF_BITS +: rcv_pkg::COEF_BITS]);
        for (int ch = 0; ch < rcv_pkg::CHANNELS; ch++) begin
          pix_taps[ch][r * rcv_pkg::KCOLS + c] =
            win_q[r][c][ch * rcv_pkg::PIX_BITS +: rcv_pkg::PIX_BITS];
        end
      end
    end
  end

  for (genvar ch = 0; ch < rcv_pkg::CHANNELS; ch++) begin : g_mul
    rcv_chan_mul u_mul (
      .pix_i  (pix_taps[ch]),
      .coef_i (coef_taps),
      .prod_o (prod_w[ch])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (w_to_p) begin
      p_vld_q <= 1'b1;
    end else if (p_done) begin
      p_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_to_p) begin
      prod_q  <= prod_w;
      p_col_q <= w_col_q;
      p_row_q <= w_row_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Result stage: sum, arithmetic shift by the norm, saturate to 0..255.
  // ---------------------------------------------------------------------------
  logic [rcv_pkg::OUT_BITS-1:0]   chan_val [rcv_pkg::CHANNELS];

  for (genvar ch = 0; ch < rcv_pkg::CHANNELS; ch++) begin : g_sum
    rcv_chan_sum u_sum (
      .prod_i  (prod_q[ch]),
      .shift_i (norm_shift_q),
      .val_o   (chan_val[ch])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (p_done) begin
      o_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      o_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_done) begin
      out_red_o   <= chan_val[0];
      out_green_o <= chan_val[1];
      out_blue_o  <= chan_val[2];
      out_row_o   <= p_row_q;
      out_col_o   <= p_col_q;
    end
  end

  assign out_valid_o = o_vld_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_accept_enters_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_vld_q)
    else $error("accepted beat did not enter stage 1");

  a_window_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_vld_q && w_emit_q && !p_free |=> w_vld_q && w_emit_q && $stable(w_row_q)
      && $stable(w_col_q))
    else $error("window beat with a result lost while product stage blocked");

  a_no_border_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_row_o != '0) && (out_col_o != '0))
    else $error("result beat at a border position");

endmodule

>>> sv/rcv_line_buf.sv
module rcv_line_buf #(
  parameter int DEPTH = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr_i,
  input  logic [rcv_pkg::LB_BITS-1:0]       wr_data_i,
  output logic [rcv_pkg::LB_BITS-1:0]       rd_data_o
);

  logic [rcv_pkg::LB_BITS-1:0] mem_q [DEPTH];
  logic [rcv_pkg::LB_BITS-1:0] rd_q;
  logic [rcv_pkg::LB_BITS-1:0] byp_data_q;
  logic                        byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // A read that meets a write to the same entry in the same cycle takes the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

>>> sv/rcv_chan_mul.sv
module rcv_chan_mul (
  input  rcv_pkg::pix_t  pix_i  [rcv_pkg::TAPS],
  input  rcv_pkg::coef_t coef_i [rcv_pkg::TAPS],
  output rcv_pkg::prod_t prod_o [rcv_pkg::TAPS]
);

  for (genvar t = 0; t < rcv_pkg::TAPS; t++) begin : g_tap
    rcv_pkg::prod_t pix_ext;
    rcv_pkg::prod_t coef_ext;
    // Zero-extend the pixel, sign-extend the coefficient, then multiply at full width.
    assign pix_ext   = rcv_pkg::prod_t'({{(rcv_pkg::PROD_BITS - rcv_pkg::PIX_BITS){1'b0}},
                                         pix_i[t]});
    assign coef_ext  = rcv_pkg::prod_t'(coef_i[t]);
    assign prod_o[t] = pix_ext * coef_ext;
  end

endmodule

>>> sv/rcv_chan_sum.sv
module rcv_chan_sum (
  input  rcv_pkg::prod_t                   prod_i [rcv_pkg::TAPS],
  input  logic [rcv_pkg::SHIFT_BITS-1:0]   shift_i,
  output logic [rcv_pkg::OUT_BITS-1:0]     val_o
);

  rcv_pkg::acc_t row_sum [rcv_pkg::KROWS];
  rcv_pkg::acc_t total;
  rcv_pkg::acc_t shifted;

  always_comb begin
    total = '0;
    for (int r = 0; r < rcv_pkg::KROWS; r++) begin
      row_sum[r] = rcv_pkg::acc_t'(prod_i[r * rcv_pkg::KCOLS])
                 + rcv_pkg::acc_t'(prod_i[r * rcv_pkg::KCOLS + 1])
                 + rcv_pkg::acc_t'(prod_i[r * rcv_pkg::KCOLS + 2]);
      total = total + row_sum[r];
    end
    // The arithmetic shift rounds toward minus infinity.
    shifted = total >>> shift_i;
    if (shifted[rcv_pkg::ACC_BITS-1]) begin
      val_o = '0;
    end else if (shifted > rcv_pkg::acc_t'(rcv_pkg::OUT_MAX)) begin
      val_o = rcv_pkg::OUT_BITS'(rcv_pkg::OUT_MAX);
    end else begin
      val_o = shifted[rcv_pkg::OUT_BITS-1:0];
    end
  end

endmodule
